// File: hdl/pde_pkg.sv
// ----------------------------------------------------------------------------
// pde_pkg
// shared types and constants of the pairwise distance engine
// ----------------------------------------------------------------------------
package pde_pkg;

   localparam int unsigned COORD_W   = 24;
   localparam int unsigned DIST_W    = 25;
   localparam int unsigned PIDX_W    = 4;
   localparam int unsigned DIFF_W    = COORD_W + 1;
   localparam int unsigned SQ_W      = 2 * DIFF_W;
   localparam int unsigned SUM_W     = SQ_W + 2;
   localparam int unsigned ROOT_W    = SUM_W / 2;

   localparam logic [4:0] ACT_P_RESET = 5'd2;
   localparam logic [1:0] ACT_D_RESET = 2'd3;

   localparam logic CSR_ACTIVE_PARTICLES = 1'b0;
   localparam logic CSR_ACTIVE_DIMS      = 1'b1;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_MOVE = 1'b1;

   typedef struct packed {
      logic                       mode;
      logic [PIDX_W-1:0]          particle;
      logic signed [COORD_W-1:0]  coord_x;
      logic signed [COORD_W-1:0]  coord_y;
      logic signed [COORD_W-1:0]  coord_z;
   } req_type;

   typedef struct packed {
      logic [PIDX_W-1:0] other_particle;
      logic [DIST_W-1:0] distance;
      logic              last;
   } rsp_type;

   // one pair job handed from front to back
   typedef struct packed {
      logic [PIDX_W-1:0] other;
      logic [SUM_W-1:0]  sum;
      logic              last;
   } job_type;

endpackage

// File: hdl/pde_front.sv
// ----------------------------------------------------------------------------
// pde_front
// stores positions, walks the partner list and builds squared sums
// ----------------------------------------------------------------------------
module pde_front #(
   parameter int unsigned MAX_PARTICLES = 16,
   parameter int unsigned MAX_DIMS      = 3
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  pde_pkg::req_type     req_data,
   input  logic [4:0]           act_p,
   input  logic [1:0]           act_d,
   output logic                 job_valid,
   input  logic                 job_ready,
   output pde_pkg::job_type     job_data
);
   localparam int unsigned IDX_W = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
   localparam int unsigned CNT_W = $clog2(MAX_PARTICLES + 2);
   localparam int unsigned DIM_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_FIND = 6'b000010,
      ST_DIFF = 6'b000100,
      ST_SQR  = 6'b001000,
      ST_ADD  = 6'b010000,
      ST_PUSH = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // position table, cleared by reset
   logic signed [pde_pkg::COORD_W-1:0]   pos_mem [MAX_PARTICLES][MAX_DIMS];

   logic                                 mode_ff;
   logic [pde_pkg::PIDX_W-1:0]           p_ff;
   logic signed [pde_pkg::COORD_W-1:0]   cur_ff [MAX_DIMS];
   logic [CNT_W-1:0]                     j_ff, j_in;
   logic [CNT_W-1:0]                     n_ff;
   logic [1:0]                           dims_ff;
   logic [DIM_W-1:0]                     d_ff, d_in;
   logic signed [pde_pkg::DIFF_W-1:0]    diff_ff;
   logic [pde_pkg::SQ_W-1:0]             sq_ff;
   logic [pde_pkg::SUM_W-1:0]            sum_ff, sum_in;

   logic signed [pde_pkg::COORD_W-1:0]   req_c [3];
   logic [CNT_W-1:0]  n_cl;
   logic [1:0]        d_cl;
   logic              sel_ok;
   logic [CNT_W-1:0]  next_j;
   logic              any_next;
   logic [IDX_W-1:0]  jidx;
   logic [IDX_W-1:0]  pidx;

   assign req_c[0] = req_data.coord_x;
   assign req_c[1] = req_data.coord_y;
   assign req_c[2] = req_data.coord_z;
   assign pidx     = IDX_W'(req_data.particle);

   // clamp configuration
   always_comb begin
      if (act_p < 5'd2) n_cl = CNT_W'(2);
      else if (32'(act_p) > MAX_PARTICLES) n_cl = CNT_W'(MAX_PARTICLES);
      else n_cl = CNT_W'(act_p);
      d_cl = act_d;
      if (act_d == 2'd0) d_cl = 2'd1;
      if (32'(act_d) > MAX_DIMS) d_cl = 2'(MAX_DIMS);
   end

   // partner selection (j ascending, skip self; in load mode only j below the particle)
   function automatic logic selected(input logic [CNT_W-1:0] j, input logic m,
                                     input logic [pde_pkg::PIDX_W-1:0] p,
                                     input logic [CNT_W-1:0] n);
      logic r;
      r = (j < n) && (32'(j) != 32'(p));
      if (m == pde_pkg::MODE_LOAD && 32'(j) > 32'(p)) r = 1'b0;
      return r;
   endfunction

   // only self can sit between two partners, so look at most two ahead
   always_comb begin
      next_j   = j_ff + CNT_W'(1);
      if (!selected(next_j, mode_ff, p_ff, n_ff)) next_j = next_j + CNT_W'(1);
      any_next = selected(next_j, mode_ff, p_ff, n_ff);
   end

   assign sel_ok    = selected(j_ff, mode_ff, p_ff, n_ff);
   assign jidx      = j_ff[IDX_W-1:0];
   assign req_ready = (state_ff == ST_IDLE);

   // control: per pair, diff, square and add once per dimension, then push
   always_comb begin
      state_in = state_ff;
      j_in     = j_ff;
      d_in     = d_ff;
      sum_in   = sum_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               j_in     = '0;
               state_in = ST_FIND;
            end
         end
         ST_FIND: begin
            d_in   = '0;
            sum_in = '0;
            if (sel_ok) begin
               state_in = ST_DIFF;
            end else if (any_next) begin
               j_in     = next_j;
               state_in = ST_DIFF;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIFF: state_in = ST_SQR;
         ST_SQR:  state_in = ST_ADD;
         ST_ADD: begin
            sum_in = sum_ff + pde_pkg::SUM_W'(sq_ff);
            if (32'(d_ff) + 32'd1 >= 32'(dims_ff)) begin
               state_in = ST_PUSH;
            end else begin
               d_in     = d_ff + DIM_W'(1);
               state_in = ST_DIFF;
            end
         end
         ST_PUSH: begin
            if (job_ready) begin
               if (any_next) begin
                  j_in     = next_j;
                  d_in     = '0;
                  sum_in   = '0;
                  state_in = ST_DIFF;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign job_valid         = (state_ff == ST_PUSH);
   assign job_data.other    = pde_pkg::PIDX_W'(j_ff);
   assign job_data.sum      = sum_ff;
   assign job_data.last     = !any_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // position writes, indexes outside the table write nothing
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_PARTICLES; i++)
            for (int d = 0; d < MAX_DIMS; d++)
               pos_mem[i][d] <= '0;
      end else if (req_valid && req_ready && 32'(req_data.particle) < MAX_PARTICLES) begin
         for (int d = 0; d < MAX_DIMS; d++)
            pos_mem[pidx][d] <= req_c[d];
      end
   end

   // datapath: capture item, per-dim diff then square
   always_ff @(posedge clock) begin
      j_ff   <= j_in;
      d_ff   <= d_in;
      sum_ff <= sum_in;
      if (req_valid && req_ready) begin
         mode_ff <= req_data.mode;
         p_ff    <= req_data.particle;
         n_ff    <= n_cl;
         dims_ff <= d_cl;
         for (int d = 0; d < MAX_DIMS; d++)
            cur_ff[d] <= req_c[d];
      end
      if (state_ff == ST_DIFF)
         diff_ff <= pde_pkg::DIFF_W'(cur_ff[d_ff]) - pde_pkg::DIFF_W'(pos_mem[jidx][d_ff]);
      if (state_ff == ST_SQR)
         sq_ff <= pde_pkg::SQ_W'(diff_ff * diff_ff);
   end

endmodule

// File: hdl/pde_sqrt.sv
// ----------------------------------------------------------------------------
// pde_sqrt
// back end: bit-serial integer square root, one result bit a cycle
// ----------------------------------------------------------------------------
module pde_sqrt (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_ready,
   input  pde_pkg::job_type  job_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pde_pkg::rsp_type  rsp_data
);
   localparam int unsigned RW = pde_pkg::ROOT_W;
   localparam int unsigned CW = $clog2(RW + 1);

   logic                         busy_ff;
   logic [CW-1:0]                cnt_ff;
   logic [RW-1:0]                rem_ff;
   logic [pde_pkg::SUM_W-1:0]    val_ff;
   logic [RW-1:0]                root_ff;
   logic [pde_pkg::PIDX_W-1:0]   oth_ff;
   logic                         last_ff;
   logic                         out_v_ff;
   pde_pkg::rsp_type             out_ff;

   logic [RW+1:0] trial, rem_sh;
   logic          done;

   assign job_ready = !busy_ff;
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;
   assign done      = busy_ff && (cnt_ff == CW'(RW)) && (!out_v_ff || rsp_ready);

   // restoring step on two sum bits
   always_comb begin
      rem_sh = {rem_ff, val_ff[pde_pkg::SUM_W-1 -: 2]};
      trial  = {root_ff, 2'b01};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (done) out_v_ff <= 1'b1;
         else if (rsp_valid && rsp_ready) out_v_ff <= 1'b0;
         if (job_valid && job_ready) busy_ff <= 1'b1;
         else if (done) busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (job_valid && job_ready) begin
         val_ff  <= job_data.sum;
         rem_ff  <= '0;
         root_ff <= '0;
         cnt_ff  <= '0;
         oth_ff  <= job_data.other;
         last_ff <= job_data.last;
      end else if (busy_ff && cnt_ff != CW'(RW)) begin
         val_ff <= val_ff << 2;
         cnt_ff <= cnt_ff + CW'(1);
         if (rem_sh >= trial) begin
            rem_ff  <= RW'(rem_sh - trial);
            root_ff <= {root_ff[RW-2:0], 1'b1};
         end else begin
            rem_ff  <= RW'(rem_sh);
            root_ff <= {root_ff[RW-2:0], 1'b0};
         end
      end
      if (done) begin
         out_ff.other_particle <= oth_ff;
         out_ff.distance       <= pde_pkg::DIST_W'(root_ff);
         out_ff.last           <= last_ff;
      end
   end

   a_busy_count: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff <= CW'(RW))
      else $error("count range");
   a_done: assert property (@(posedge clock) disable iff (reset)
      (job_valid && job_ready) |=> busy_ff)
      else $error("job not taken");
   a_out: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped");

endmodule

// File: hdl/pairwise_distance_engine_unit.sv
// ----------------------------------------------------------------------------
// pairwise_distance_engine_unit
// the bit-serial root sets the pace and takes one pair job at a time
// a new request is taken only after the last job of the previous one is pushed
// reset: synchronous, positions read as zero, registers to 2 and 3
// ----------------------------------------------------------------------------
module pairwise_distance_engine_unit #(
   parameter int unsigned MAX_PARTICLES = 16,
   parameter int unsigned MAX_DIMS      = 3
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pde_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pde_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [4:0]        csr_data
);
   logic [4:0] act_p_ff;
   logic [1:0] act_d_ff;
   logic       job_valid, job_ready;
   pde_pkg::job_type job_data;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         act_p_ff <= pde_pkg::ACT_P_RESET;
         act_d_ff <= pde_pkg::ACT_D_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            pde_pkg::CSR_ACTIVE_PARTICLES: act_p_ff <= csr_data;
            pde_pkg::CSR_ACTIVE_DIMS:      act_d_ff <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   pde_front #(.MAX_PARTICLES(MAX_PARTICLES), .MAX_DIMS(MAX_DIMS)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .act_p(act_p_ff), .act_d(act_d_ff),
      .job_valid, .job_ready, .job_data
   );

   pde_sqrt u_sqrt (
      .clock, .reset, .job_valid, .job_ready, .job_data,
      .rsp_valid, .rsp_ready, .rsp_data
   );

endmodule
